// File: src/mrpm_pkg.sv
// mrpm_pkg: shared types and constants of the multichannel rms and peak meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mrpm_pkg;

	localparam int unsigned MAX_CHANNELS = 8;
	localparam int unsigned SAMPLE_BITS  = 24;

	localparam int unsigned SUM_W   = 64;
	localparam int unsigned FRAME_W = 48;
	localparam int unsigned WIN_W   = 18;
	localparam int unsigned OUT_W   = 24;

	typedef enum logic [1:0] {
		FUNC_SAMPLE    = 2'd0,
		FUNC_RST_RMS   = 2'd1,
		FUNC_RST_PEAK  = 2'd2,
		FUNC_UNUSED    = 2'd3
	} func_t;

	localparam logic CFG_NUM_CHANNELS  = 1'b0;
	localparam logic CFG_WINDOW_FRAMES = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  channel;
		logic [23:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  report_channel;
		logic [23:0] average_rms;
		logic [23:0] window_rms;
		logic [23:0] absolute_peak;
		logic [23:0] window_peak;
		logic        last_report;
	} out_item_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_UPD,
		ST_RPT_RD,
		ST_RPT_DIV,
		ST_RPT_SQRT,
		ST_RPT_OUT
	} state_t;

	// request to the divide / root unit
	typedef struct packed {
		logic                start;
		logic [SUM_W-1:0]    num;
		logic [FRAME_W-1:0]  den;
	} rms_req_t;

	typedef struct packed {
		logic              done;
		logic [OUT_W-1:0]  root;
	} rms_rsp_t;

endpackage
`default_nettype wire

// File: src/mrpm_rms_unit.sv
// mrpm_rms_unit: iterative floor(sqrt(floor(num / den))) with full-scale clamp
// depends on mrpm_pkg
`timescale 1ns / 1ps
`default_nettype none
module mrpm_rms_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mrpm_pkg::rms_req_t req,
	output mrpm_pkg::rms_rsp_t      rsp
);
	localparam int unsigned SW = mrpm_pkg::SUM_W;
	localparam int unsigned FW = mrpm_pkg::FRAME_W;
	localparam logic [SW-1:0] FULL = SW'(1) << (mrpm_pkg::SAMPLE_BITS - 1);

	typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT} ustate_t;

	ustate_t         st_q;
	logic [6:0]      cnt_q;
	logic [SW-1:0]   quo_q;
	logic [FW:0]     rem_q;
	logic [FW-1:0]   den_q;
	logic [SW-1:0]   res_q;
	logic [SW-1:0]   val_q;
	logic [SW-1:0]   bit_q;
	logic            zero_q;
	logic            done_q;

	// restoring divide step, one quotient bit a cycle
	logic [FW:0]   rem_sh;
	logic          take;
	assign rem_sh = {rem_q[FW-1:0], quo_q[SW-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	// root step, two bits of radicand a cycle
	logic [SW-1:0] trial;
	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			res_q  <= '0;
			val_q  <= '0;
			bit_q  <= '0;
			zero_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				U_IDLE: begin
					if (req.start) begin
						quo_q  <= req.num;
						rem_q  <= '0;
						den_q  <= req.den;
						zero_q <= (req.den == '0);
						cnt_q  <= 7'(SW);
						st_q   <= U_DIV;
					end
				end
				U_DIV: begin
					rem_q <= take ? rem_sh - {1'b0, den_q} : rem_sh;
					quo_q <= {quo_q[SW-2:0], take};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						val_q <= {quo_q[SW-2:0], take};
						res_q <= '0;
						bit_q <= SW'(1) << (SW - 2);
						cnt_q <= 7'(SW / 2);
						st_q  <= U_SQRT;
					end
				end
				U_SQRT: begin
					if (val_q >= trial) begin
						val_q <= val_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						done_q <= 1'b1;
						st_q   <= U_IDLE;
					end
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	logic [SW-1:0] clamped;
	assign clamped = zero_q ? '0 : ((res_q > FULL) ? FULL : res_q);
	assign rsp.done = done_q;
	assign rsp.root = clamped[mrpm_pkg::OUT_W-1:0];

	a_done_from_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(st_q) == U_SQRT)
		else $error("rms unit done without root pass");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != U_IDLE) |=> !(done_q && st_q == U_DIV))
		else $error("rms unit restarted while busy");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> 1'b1 ##0 ($past(clamped) <= FULL))
		else $error("rms result above full scale");
endmodule
`default_nettype wire

// File: src/multichannel_rms_peak_meter_top.sv
// multichannel_rms_peak_meter_top: per-channel rms and peak meter, state in one memory
// depends on mrpm_pkg and mrpm_rms_unit
//
// channel  dir  handshake        payload
// in       in   in_valid/stall   mrpm_pkg::in_item_t
// out      out  out_valid/stall  mrpm_pkg::out_item_t
// cfg      in   cfg_valid/ready  cfg_index, cfg_data
//
// a sample goes through accept, memory read, then update and write back; a command
// sweeps MAX_CHANNELS entries read then write. a window end adds per channel a read,
// two passes of start, divide, root and handoff on the shared rms unit, then the
// output load, which waits while a report is stalled. after the last report a sweep
// clears every window entry. after reset a clearing pass zeroes the memory.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_rms_peak_meter_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire mrpm_pkg::in_item_t    in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output mrpm_pkg::out_item_t        out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_index,
	input  wire logic [17:0]           cfg_data
);
	localparam int unsigned MAX_CHANNELS = mrpm_pkg::MAX_CHANNELS;
	localparam int unsigned SAMPLE_BITS  = mrpm_pkg::SAMPLE_BITS;
	localparam int unsigned SW = mrpm_pkg::SUM_W;
	localparam int unsigned FW = mrpm_pkg::FRAME_W;
	localparam int unsigned WW = mrpm_pkg::WIN_W;
	localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned PW = mrpm_pkg::OUT_W;

	typedef struct packed {
		logic [SW-1:0] tot;
		logic [SW-1:0] win;
		logic [PW-1:0] pk;
		logic [PW-1:0] pkw;
	} entry_t;

	// state memory, one entry per channel
	entry_t mem [MAX_CHANNELS];
	entry_t rd_s1;
	logic           we;
	logic [AW-1:0]  waddr, raddr;
	entry_t         wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[raddr];
	end

	// configuration
	logic [3:0]    nch_q;
	logic [WW-1:0] wlen_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q  <= 4'd2;
			wlen_q <= WW'(3043);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mrpm_pkg::CFG_NUM_CHANNELS:  nch_q  <= cfg_data[3:0];
				mrpm_pkg::CFG_WINDOW_FRAMES: wlen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [5:0]    nc;
	logic [WW-1:0] wl;
	assign nc = (nch_q == 4'd0) ? 6'd1 :
		((32'(nch_q) > MAX_CHANNELS) ? 6'(MAX_CHANNELS) : 6'(nch_q));
	assign wl = (wlen_q == '0) ? WW'(1) : wlen_q;

	mrpm_pkg::state_t st_q, st_d;
	logic [AW:0]      idx_q;
	mrpm_pkg::in_item_t item_q;
	logic [FW-1:0]    ftot_q;
	logic [WW-1:0]    wcnt_q;
	logic [PW-1:0]    avg_q;
	logic [PW-1:0]    wrms_q;
	logic             ovld_q;
	logic             rms_phase_q;
	mrpm_pkg::rms_req_t req;
	mrpm_pkg::rms_rsp_t rsp;

	mrpm_rms_unit u_rms (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	// sample magnitude and square
	logic [SAMPLE_BITS-1:0] raw;
	logic [PW-1:0]          mag;
	logic [2*PW-1:0]        sq_p;
	logic [SW-1:0]          sq;
	assign raw = item_q.sample;
	always_comb begin
		logic [SAMPLE_BITS-1:0] neg;
		neg = ~raw + 1'b1;
		if (raw[SAMPLE_BITS-1]) mag = (neg == '0) ? PW'(1 << (SAMPLE_BITS-1)) : PW'(neg);
		else mag = PW'(raw);
	end
	assign sq_p = mag * mag;
	assign sq = SW'(sq_p);

	logic [AW-1:0] ch;
	assign ch = item_q.channel[AW-1:0];
	logic [SW:0] tsum, wsum;
	assign tsum = {1'b0, rd_s1.tot} + {1'b0, sq};
	assign wsum = {1'b0, rd_s1.win} + {1'b0, sq};
	logic last_ch;
	assign last_ch = (6'(item_q.channel) == nc - 6'd1);
	logic [WW-1:0] wcnt_inc;
	assign wcnt_inc = (wcnt_q == '1) ? wcnt_q : wcnt_q + 1'b1;

	assign in_stall = (st_q != mrpm_pkg::ST_IDLE);
	logic acc;
	assign acc = in_valid && !in_stall;

	// sequencer
	always_comb begin
		st_d  = st_q;
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		raddr = idx_q[AW-1:0];
		wdata = rd_s1;
		req.start = 1'b0;
		req.num = rd_s1.tot;
		req.den = ftot_q;
		unique case (st_q)
			mrpm_pkg::ST_IDLE: begin
				raddr = in_data.channel[AW-1:0];
				if (acc) begin
					if (in_data.func == mrpm_pkg::FUNC_RST_RMS ||
						in_data.func == mrpm_pkg::FUNC_RST_PEAK) st_d = mrpm_pkg::ST_CLEAR;
					else if (in_data.func == mrpm_pkg::FUNC_SAMPLE &&
						6'(in_data.channel) < nc) st_d = mrpm_pkg::ST_RD;
				end
			end
			mrpm_pkg::ST_CLEAR: begin
				// reset clearing pass, command sweep or window sweep, read then write
				raddr = idx_q[AW-1:0];
				st_d = mrpm_pkg::ST_CLEAR;
				if (rms_phase_q) begin
					we = 1'b1;
					waddr = idx_q[AW-1:0] - 1'b1;
					wdata = rd_s1;
					if (item_q.func == mrpm_pkg::FUNC_RST_RMS) wdata.tot = '0;
					else if (item_q.func == mrpm_pkg::FUNC_RST_PEAK) wdata.pk = '0;
					else if (item_q.func == mrpm_pkg::FUNC_SAMPLE) begin
						wdata.win = '0;
						wdata.pkw = '0;
					end
					else wdata = '0;
				end
				if (rms_phase_q && 32'(idx_q) == MAX_CHANNELS) st_d = mrpm_pkg::ST_IDLE;
			end
			mrpm_pkg::ST_RD: begin
				raddr = ch;
				st_d = mrpm_pkg::ST_UPD;
			end
			mrpm_pkg::ST_UPD: begin
				we = 1'b1;
				waddr = ch;
				wdata.tot = tsum[SW] ? '1 : tsum[SW-1:0];
				wdata.win = wsum[SW] ? '1 : wsum[SW-1:0];
				wdata.pk  = (mag > rd_s1.pk) ? mag : rd_s1.pk;
				wdata.pkw = (mag > rd_s1.pkw) ? mag : rd_s1.pkw;
				st_d = (last_ch && wcnt_inc >= wl) ? mrpm_pkg::ST_RPT_RD
					: mrpm_pkg::ST_IDLE;
			end
			mrpm_pkg::ST_RPT_RD: begin
				raddr = idx_q[AW-1:0];
				st_d = mrpm_pkg::ST_RPT_DIV;
			end
			mrpm_pkg::ST_RPT_DIV: begin
				req.start = 1'b1;
				req.num = rms_phase_q ? rd_s1.win : rd_s1.tot;
				req.den = rms_phase_q ? FW'(wcnt_q) : ftot_q;
				st_d = mrpm_pkg::ST_RPT_SQRT;
			end
			mrpm_pkg::ST_RPT_SQRT: begin
				if (rsp.done) st_d = rms_phase_q ? mrpm_pkg::ST_RPT_OUT
					: mrpm_pkg::ST_RPT_DIV;
			end
			mrpm_pkg::ST_RPT_OUT: begin
				if (!ovld_q || !out_stall) begin
					we = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata.win = '0;
					wdata.pkw = '0;
					st_d = (6'(idx_q) + 6'd1 == nc) ? mrpm_pkg::ST_CLEAR
						: mrpm_pkg::ST_RPT_RD;
				end
			end
			default: st_d = mrpm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= mrpm_pkg::ST_CLEAR;
		else st_q <= st_d;
	end

	// output register valid
	logic out_load;
	assign out_load = (st_q == mrpm_pkg::ST_RPT_OUT) && (!ovld_q || !out_stall);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (out_load) ovld_q <= 1'b1;
		else if (!out_stall) ovld_q <= 1'b0;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rms_phase_q <= 1'b0;
			ftot_q      <= '0;
			wcnt_q      <= '0;
			avg_q       <= '0;
			wrms_q      <= '0;
			out_data    <= '0;
			item_q      <= '{func: mrpm_pkg::FUNC_UNUSED, channel: '0, sample: '0};
		end else begin
			unique case (st_q)
				mrpm_pkg::ST_IDLE: begin
					if (acc) begin
						item_q      <= in_data;
						idx_q       <= '0;
						rms_phase_q <= 1'b0;
						if (in_data.func == mrpm_pkg::FUNC_RST_RMS) ftot_q <= '0;
					end
				end
				mrpm_pkg::ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					rms_phase_q <= 1'b1;
				end
				mrpm_pkg::ST_UPD: begin
					if (last_ch) begin
						if (ftot_q != '1) ftot_q <= ftot_q + 1'b1;
						wcnt_q <= wcnt_inc;
					end
					idx_q <= '0;
					rms_phase_q <= 1'b0;
				end
				mrpm_pkg::ST_RPT_SQRT: begin
					if (rsp.done) begin
						if (!rms_phase_q) avg_q <= rsp.root;
						else wrms_q <= rsp.root;
						rms_phase_q <= ~rms_phase_q;
					end
				end
				mrpm_pkg::ST_RPT_OUT: begin
					if (!ovld_q || !out_stall) begin
						out_data.report_channel <= 3'(idx_q);
						out_data.average_rms    <= avg_q;
						out_data.window_rms     <= wrms_q;
						out_data.absolute_peak  <= rd_s1.pk;
						out_data.window_peak    <= rd_s1.pkw;
						out_data.last_report    <= (6'(idx_q) + 6'd1 == nc);
						if (6'(idx_q) + 6'd1 == nc) begin
							wcnt_q <= '0;
							idx_q  <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end
	assign out_valid = ovld_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != mrpm_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_only_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> $past(st_q) == mrpm_pkg::ST_RPT_OUT)
		else $error("report raised outside report state");
	a_win_reset: assert property (@(posedge clk) disable iff (!arst_n)
		($past(st_q) == mrpm_pkg::ST_RPT_OUT && st_q == mrpm_pkg::ST_CLEAR) |->
		wcnt_q == '0)
		else $error("window count not cleared after reports");
endmodule
`default_nettype wire

// File: verif/mrpm_checker.sv
// mrpm_checker: watches the meter's channels, predicts reports and compares them
// depends on mrpm_pkg
`timescale 1ns / 1ps
`default_nettype none
module mrpm_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire mrpm_pkg::in_item_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire mrpm_pkg::out_item_t out_data,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [17:0]         cfg_data,
	output int                       pending,
	output int                       fail_count,
	output int                       report_count
);
	localparam bit [63:0] FULL_SCALE = 64'd1 << 23;

	// meter copy: settings and per-channel accumulators
	bit [3:0]  chan_setting;
	bit [17:0] window_setting;
	bit [63:0] total_sq [8];
	bit [63:0] window_sq [8];
	bit [23:0] peak_total [8];
	bit [23:0] peak_window [8];
	bit [47:0] frames_seen;
	bit [17:0] frames_in_window;

	mrpm_pkg::out_item_t expected_reports [$];

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res;
		bit [63:0] b;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic bit [23:0] level_of(bit [63:0] sum, bit [47:0] frames);
		bit [63:0] r;
		if (frames == 0)
			return '0;
		r = int_sqrt(sum / {16'd0, frames});
		if (r > FULL_SCALE)
			r = FULL_SCALE;
		return r[23:0];
	endfunction

	function automatic bit [63:0] add_clamped(bit [63:0] a, bit [63:0] b);
		bit [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	task automatic clear_all();
		for (int k = 0; k < 8; k++) begin
			total_sq[k] = '0;
			window_sq[k] = '0;
			peak_total[k] = '0;
			peak_window[k] = '0;
		end
		frames_seen = '0;
		frames_in_window = '0;
		chan_setting = 4'd2;
		window_setting = 18'd3043;
	endtask

	// fold one accepted transaction into the meter copy
	task automatic absorb_item(mrpm_pkg::in_item_t it);
		int unsigned nc;
		int unsigned wlen;
		int unsigned ch;
		bit [24:0] mag;
		bit [63:0] sq;
		mrpm_pkg::out_item_t rep;
		nc = (chan_setting == 0) ? 1 : (chan_setting > 8) ? 8 : chan_setting;
		wlen = (window_setting == 0) ? 1 : window_setting;
		ch = it.channel;
		case (mrpm_pkg::func_t'(it.func))
			mrpm_pkg::FUNC_RST_RMS: begin
				for (int k = 0; k < 8; k++)
					total_sq[k] = '0;
				frames_seen = '0;
			end
			mrpm_pkg::FUNC_RST_PEAK: begin
				for (int k = 0; k < 8; k++)
					peak_total[k] = '0;
			end
			mrpm_pkg::FUNC_SAMPLE: begin
				if (ch < nc) begin
					mag = it.sample[23] ? (25'h1000000 - {1'b0, it.sample}) : {1'b0, it.sample};
					sq = {39'd0, mag} * {39'd0, mag};
					total_sq[ch] = add_clamped(total_sq[ch], sq);
					window_sq[ch] = add_clamped(window_sq[ch], sq);
					if (mag[23:0] > peak_total[ch])
						peak_total[ch] = mag[23:0];
					if (mag[23:0] > peak_window[ch])
						peak_window[ch] = mag[23:0];
					if (ch == nc - 1) begin
						if (frames_seen != '1)
							frames_seen++;
						if (frames_in_window != '1)
							frames_in_window++;
						if (frames_in_window >= wlen) begin
							for (int k = 0; k < nc; k++) begin
								rep.report_channel = k[2:0];
								rep.average_rms = level_of(total_sq[k], frames_seen);
								rep.window_rms = level_of(window_sq[k], {30'd0, frames_in_window});
								rep.absolute_peak = peak_total[k];
								rep.window_peak = peak_window[k];
								rep.last_report = (k == nc - 1);
								expected_reports.push_back(rep);
							end
							for (int k = 0; k < 8; k++) begin
								window_sq[k] = '0;
								peak_window[k] = '0;
							end
							frames_in_window = '0;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("%0t ns: report mismatch on %s: got %0d, expected %0d",
			$realtime, what, got, want);
		fail_count++;
	endtask

	// sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		mrpm_pkg::out_item_t want;
		if (!arst_n) begin
			clear_all();
			expected_reports.delete();
			fail_count = 0;
			report_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mrpm_pkg::CFG_NUM_CHANNELS)
					chan_setting = cfg_data[3:0];
				else
					window_setting = cfg_data;
			end
			if (in_valid && !in_stall)
				absorb_item(in_data);
			if (out_valid && !out_stall) begin
				report_count++;
				if (expected_reports.size() == 0) begin
					$display("%0t ns: report transaction with nothing expected", $realtime);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (out_data.report_channel != want.report_channel)
						report_mismatch("report_channel", out_data.report_channel,
							want.report_channel);
					if (out_data.average_rms != want.average_rms)
						report_mismatch("average_rms", out_data.average_rms, want.average_rms);
					if (out_data.window_rms != want.window_rms)
						report_mismatch("window_rms", out_data.window_rms, want.window_rms);
					if (out_data.absolute_peak != want.absolute_peak)
						report_mismatch("absolute_peak", out_data.absolute_peak,
							want.absolute_peak);
					if (out_data.window_peak != want.window_peak)
						report_mismatch("window_peak", out_data.window_peak, want.window_peak);
					if (out_data.last_report != want.last_report)
						report_mismatch("last_report", out_data.last_report, want.last_report);
				end
			end
			pending = expected_reports.size();
		end
	end

endmodule
`default_nettype wire

// File: verif/tb_multichannel_rms_peak_meter_top.sv
// tb_multichannel_rms_peak_meter_top: stimulus, handshake pacing and verdict for the meter
// depends on mrpm_pkg, multichannel_rms_peak_meter_top and mrpm_checker
`timescale 1ns / 1ps
`default_nettype none
module tb_multichannel_rms_peak_meter_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mrpm_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mrpm_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = mrpm_pkg::CFG_NUM_CHANNELS;
	logic [17:0] cfg_data = '0;

	int pending;
	int fail_count;
	int report_count;

	// pacing knobs, gap and stall in percent per cycle, plus the hold-off request
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int active_channels = 2;
	int items_sent = 0;
	int settings_used = 0;

	always #4 clk = ~clk;

	multichannel_rms_peak_meter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mrpm_checker meter_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .fail_count(fail_count), .report_count(report_count)
	);

	// receiver side: random stall plus the long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
		end
		out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
	end

	task automatic send_item(logic [1:0] f, logic [2:0] ch, logic [23:0] s);
		mrpm_pkg::in_item_t it;
		it.func = f;
		it.channel = ch;
		it.sample = s;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (f != mrpm_pkg::FUNC_UNUSED &&
			!(f == mrpm_pkg::FUNC_SAMPLE && ch >= active_channels))
			items_sent++;
	endtask

	// quiet point: all reports in, then room for a report sequence to drain
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (1200) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [17:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == mrpm_pkg::CFG_NUM_CHANNELS)
			active_channels = (val[3:0] == 0) ? 1 : (val[3:0] > 8) ? 8 : val[3:0];
		settings_used++;
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return ($urandom_range(1) == 0) ? 24'hFFFFFF : 24'h000000;
			default: return 24'($urandom());
		endcase
	endfunction

	// mostly whole frames in channel order, some noise and broken frames
	task automatic random_items(int target);
		int start;
		start = items_sent;
		while (items_sent - start < target) begin
			if ($urandom_range(99) < 85) begin
				for (int c = 0; c < active_channels; c++)
					send_item(mrpm_pkg::FUNC_SAMPLE, c[2:0], pick_sample());
			end else begin
				send_item(2'($urandom_range(3)), 3'($urandom_range(7)), pick_sample());
			end
		end
	endtask

	task automatic run_phase(logic [3:0] nc, logic [17:0] wf, int gap, int stall, int n);
		settle();
		write_reg(mrpm_pkg::CFG_NUM_CHANNELS, {14'd0, nc});
		write_reg(mrpm_pkg::CFG_WINDOW_FRAMES, wf);
		send_gap_pct = gap;
		stall_pct = stall;
		random_items(n);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: two channels, report on every frame
		write_reg(mrpm_pkg::CFG_NUM_CHANNELS, 18'd2);
		write_reg(mrpm_pkg::CFG_WINDOW_FRAMES, 18'd1);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h7FFFFF);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd1, 24'h800000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h000000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd1, 24'hFFFFFF);
		send_item(mrpm_pkg::FUNC_UNUSED, 3'd7, 24'h555555);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd2, 24'hAAAAAA);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd7, 24'h7FFFFF);
		send_item(mrpm_pkg::FUNC_RST_RMS, 3'd0, 24'h000000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h555555);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd1, 24'hAAAAAA);
		send_item(mrpm_pkg::FUNC_RST_PEAK, 3'd5, 24'hFFFFFF);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h000001);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd1, 24'h000001);
		// channel repeated inside a frame drives the level past full scale
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h800000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h800000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd0, 24'h800000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd1, 24'h800000);
		send_item(mrpm_pkg::FUNC_SAMPLE, 3'd1, 24'h800000);

		run_phase(4'd1, 18'd1, 0, 0, 40);
		run_phase(4'd8, 18'd2, 65, 0, 50);
		run_phase(4'd0, 18'd1, 0, 65, 40);
		run_phase(4'd15, 18'd1, 29, 29, 40);
		run_phase(4'd3, 18'd0, 0, 0, 30);
		run_phase(4'd5, 18'd3, 29, 29, 30);

		// receiver holds off while eight-channel reports wait to be taken
		settle();
		write_reg(mrpm_pkg::CFG_NUM_CHANNELS, 18'd8);
		write_reg(mrpm_pkg::CFG_WINDOW_FRAMES, 18'd1);
		send_gap_pct = 0;
		stall_pct = 0;
		hold_req++;
		random_items(40);

		// longest window, then shortened while frames are already counted
		run_phase(4'd4, 18'd262143, 65, 0, 20);
		settle();
		write_reg(mrpm_pkg::CFG_WINDOW_FRAMES, 18'd2);
		send_gap_pct = 0;
		stall_pct = 65;
		random_items(12);

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (1200) @(negedge clk);
		$display("covered %0d transactions over %0d register writes, %0d reports compared",
			items_sent, settings_used, report_count);
		if (fail_count == 0 && pending == 0)
			$display("multichannel_rms_peak_meter_top verification clean");
		else
			$display("multichannel_rms_peak_meter_top verification failed");
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("timeout with %0d reports outstanding", pending);
		$display("multichannel_rms_peak_meter_top verification failed");
		$finish;
	end

endmodule
`default_nettype wire
